>>> sv/cir_pkg.sv
// ----------------------------------------------------------------------------
// cir_pkg: shared definitions for the channel interleave reorder block
// Frame geometry, field widths, command and register codes, and the result
// beat that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package cir_pkg;

  // Frame geometry.
  localparam int FRAMES       = 1024;
  localparam int MAX_CHANNELS = 8;
  localparam int STORE_DEPTH  = FRAMES * MAX_CHANNELS;
  localparam int FRAME_BITS   = $clog2(FRAMES);
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int COUNT_W      = ADDR_W + 1;
  localparam int CHAN_W       = 4;
  localparam int CTR_W        = (FRAME_BITS > CHAN_W) ? FRAME_BITS : CHAN_W;
  localparam int SAMPLE_W     = 32;

  // Result queue geometry.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CHAN_W;

  // Channel count after reset.
  localparam logic [CHAN_W-1:0] CHANNELS_RESET = CHAN_W'(2);

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 1'b0,
    REG_DIRECTION     = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    DIR_TO_GROUPED     = 1'b0,
    DIR_TO_INTERLEAVED = 1'b1
  } dir_t;

  // One result beat.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                empty;
  } res_beat_t;

endpackage

>>> sv/cir_ram.sv
// ----------------------------------------------------------------------------
// cir_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module cir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/cir_front.sv
// ----------------------------------------------------------------------------
// cir_front: command front end
// Holds the configuration, the load and read counters and the frame store.
// Loads write the store in arrival order; reads step the source address with
// nested counters and produce one result beat in the next cycle.
// ----------------------------------------------------------------------------
module cir_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic                              command,
  input  logic [cir_pkg::SAMPLE_W-1:0]      sample_in,
  input  logic                              cfg_we,
  input  logic [cir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cir_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              push,
  output cir_pkg::res_beat_t                push_beat,
  output logic                              stage_busy
);

  // Configuration registers.
  logic [cir_pkg::CHAN_W-1:0]  chan_cfg_r, chan_cfg_nxt;
  cir_pkg::dir_t               dir_r, dir_nxt;

  // Frame counters.
  logic [cir_pkg::COUNT_W-1:0] load_count_r, load_count_nxt;
  logic [cir_pkg::COUNT_W-1:0] read_count_r, read_count_nxt;
  logic                        full_r, full_nxt;
  logic [cir_pkg::CTR_W-1:0]   outer_r, outer_nxt;
  logic [cir_pkg::CTR_W-1:0]   inner_r, inner_nxt;
  logic [cir_pkg::ADDR_W-1:0]  src_r, src_nxt;

  // Read stage toward the queue.
  logic                        s1_valid_r, s1_valid_nxt;
  logic                        s1_last_r, s1_last_nxt;
  logic                        s1_empty_r, s1_empty_nxt;

  logic [cir_pkg::CHAN_W-1:0]  chans;
  logic [cir_pkg::COUNT_W-1:0] total;
  logic [cir_pkg::COUNT_W-1:0] load_inc;
  logic [cir_pkg::COUNT_W-1:0] read_inc;
  logic [cir_pkg::ADDR_W-1:0]  src_step;
  logic                        inner_wrap;
  logic                        is_load;
  logic                        is_read;
  logic                        do_write;
  logic                        do_read;
  logic                        read_last;
  logic [cir_pkg::SAMPLE_W-1:0] rd_data;

  // Clamp the channel count to the supported range.
  always_comb begin
    if (chan_cfg_r == '0) begin
      chans = cir_pkg::CHAN_W'(1);
    end else if (chan_cfg_r > cir_pkg::CHAN_W'(cir_pkg::MAX_CHANNELS)) begin
      chans = cir_pkg::CHAN_W'(cir_pkg::MAX_CHANNELS);
    end else begin
      chans = chan_cfg_r;
    end
  end

  // Frame length is the channel count times a power-of-two frame count.
  assign total    = cir_pkg::COUNT_W'(chans) << cir_pkg::FRAME_BITS;
  assign load_inc = load_count_r + cir_pkg::COUNT_W'(1);
  assign read_inc = read_count_r + cir_pkg::COUNT_W'(1);

  assign is_load   = accept && (command == cir_pkg::CMD_LOAD);
  assign is_read   = accept && (command == cir_pkg::CMD_READ);
  assign do_write  = is_load && !full_r;
  assign do_read   = is_read && full_r;
  assign read_last = (read_inc >= total);

  // Source address step and inner wrap depend on the direction.
  always_comb begin
    if (dir_r == cir_pkg::DIR_TO_GROUPED) begin
      src_step   = cir_pkg::ADDR_W'(chans);
      inner_wrap = (inner_r == cir_pkg::CTR_W'(cir_pkg::FRAMES - 1));
    end else begin
      src_step   = cir_pkg::ADDR_W'(cir_pkg::FRAMES);
      inner_wrap = (inner_r == cir_pkg::CTR_W'(chans - cir_pkg::CHAN_W'(1)));
    end
  end

  // Next-state logic for configuration and counters.
  always_comb begin
    chan_cfg_nxt   = chan_cfg_r;
    dir_nxt        = dir_r;
    load_count_nxt = load_count_r;
    read_count_nxt = read_count_r;
    full_nxt       = full_r;
    outer_nxt      = outer_r;
    inner_nxt      = inner_r;
    src_nxt        = src_r;
    s1_valid_nxt   = is_read;
    s1_last_nxt    = do_read && read_last;
    s1_empty_nxt   = !full_r;

    if (cfg_we) begin
      // Any register write empties the frame.
      unique case (cir_pkg::reg_idx_t'(cfg_index))
        cir_pkg::REG_CHANNEL_COUNT: chan_cfg_nxt = cfg_data;
        cir_pkg::REG_DIRECTION:     dir_nxt = cir_pkg::dir_t'(cfg_data[0]);
        default:                    chan_cfg_nxt = chan_cfg_r;
      endcase
      load_count_nxt = '0;
      read_count_nxt = '0;
      full_nxt       = 1'b0;
      outer_nxt      = '0;
      inner_nxt      = '0;
      src_nxt        = '0;
    end else if (do_write) begin
      load_count_nxt = load_inc;
      if (load_inc >= total) begin
        full_nxt = 1'b1;
      end
    end else if (do_read) begin
      if (read_last) begin
        load_count_nxt = '0;
        read_count_nxt = '0;
        full_nxt       = 1'b0;
        outer_nxt      = '0;
        inner_nxt      = '0;
        src_nxt        = '0;
      end else begin
        read_count_nxt = read_inc;
        if (inner_wrap) begin
          inner_nxt = '0;
          outer_nxt = outer_r + cir_pkg::CTR_W'(1);
          src_nxt   = cir_pkg::ADDR_W'(outer_r + cir_pkg::CTR_W'(1));
        end else begin
          inner_nxt = inner_r + cir_pkg::CTR_W'(1);
          src_nxt   = src_r + src_step;
        end
      end
    end
  end

  // Control and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cfg_r   <= cir_pkg::CHANNELS_RESET;
      dir_r        <= cir_pkg::DIR_TO_GROUPED;
      load_count_r <= '0;
      read_count_r <= '0;
      full_r       <= 1'b0;
      outer_r      <= '0;
      inner_r      <= '0;
      src_r        <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      chan_cfg_r   <= chan_cfg_nxt;
      dir_r        <= dir_nxt;
      load_count_r <= load_count_nxt;
      read_count_r <= read_count_nxt;
      full_r       <= full_nxt;
      outer_r      <= outer_nxt;
      inner_r      <= inner_nxt;
      src_r        <= src_nxt;
      s1_valid_r   <= s1_valid_nxt;
    end
  end

  // Flags of the read stage.
  always_ff @(posedge clk) begin
    s1_last_r  <= s1_last_nxt;
    s1_empty_r <= s1_empty_nxt;
  end

  // Frame store.
  cir_ram #(
    .WIDTH (cir_pkg::SAMPLE_W),
    .DEPTH (cir_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_write),
    .wr_addr (load_count_r[cir_pkg::ADDR_W-1:0]),
    .wr_data (sample_in),
    .rd_en   (do_read),
    .rd_addr (src_r),
    .rd_data (rd_data)
  );

  // Result beat for the queue; an empty read carries zero data.
  assign push             = s1_valid_r;
  assign push_beat.sample = s1_empty_r ? '0 : rd_data;
  assign push_beat.last   = s1_last_r;
  assign push_beat.empty  = s1_empty_r;
  assign stage_busy       = s1_valid_r;

endmodule

>>> sv/cir_queue.sv
// ----------------------------------------------------------------------------
// cir_queue: short result queue
// Decouples the front end from the back end; holds up to two result beats.
// ----------------------------------------------------------------------------
module cir_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  cir_pkg::res_beat_t            push_beat,
  input  logic                          pop,
  output logic                          not_empty,
  output cir_pkg::res_beat_t            head,
  output logic [cir_pkg::QCNT_W-1:0]    count
);

  cir_pkg::res_beat_t              slot_r [cir_pkg::QUEUE_DEPTH];
  logic [cir_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [cir_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [cir_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                            do_pop;

  assign do_pop = pop && (count_r != '0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + cir_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + cir_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + cir_pkg::QCNT_W'(push) - cir_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Beat storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_beat;
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign count     = count_r;

endmodule

>>> sv/cir_back.sv
// ----------------------------------------------------------------------------
// cir_back: result back end
// Takes one beat from the queue each cycle and presents it on the result
// ports for one cycle with a strobe.
// ----------------------------------------------------------------------------
module cir_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          not_empty,
  input  cir_pkg::res_beat_t            head,
  output logic                          pop,
  output logic                          out_strobe,
  output logic [cir_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                          out_last,
  output logic                          out_empty_res
);

  logic               strobe_r, strobe_nxt;
  cir_pkg::res_beat_t beat_r, beat_nxt;

  // The receiver never stalls, so a waiting beat is always taken.
  always_comb begin
    pop        = not_empty;
    strobe_nxt = not_empty;
    beat_nxt   = not_empty ? head : beat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_sample_out = beat_r.sample;
  assign out_last       = beat_r.last;
  assign out_empty_res  = beat_r.empty;

endmodule

>>> sv/channel_interleave_reorder.sv
// ----------------------------------------------------------------------------
// channel_interleave_reorder: audio frame interleave/deinterleave reorder
// Takes one command per clock while busy is low: a load stores a sample word
// until the frame is full; a read returns the next sample of the full
// reordered frame, else an empty result. Each read produces exactly one
// result, through the store read stage, queue and output register; loads
// produce none. The output side drains one beat every cycle, so the result
// queue never holds more than one beat. Busy, however, counts the queued beat
// and the beat in the read stage without crediting the drain of the same
// cycle, so busy rises after every two back-to-back reads. Loads never raise
// busy and go at one per cycle, the peak rate of the single frame store with
// one write and one read port. A register write empties the frame.
// ----------------------------------------------------------------------------
module channel_interleave_reorder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [cir_pkg::SAMPLE_W-1:0]      in_sample_in,
  output logic                              out_strobe,
  output logic [cir_pkg::SAMPLE_W-1:0]      out_sample_out,
  output logic                              out_last,
  output logic                              out_empty_res,
  input  logic                              cfg_we,
  input  logic [cir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cir_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                             accept;
  logic                             push;
  cir_pkg::res_beat_t               push_beat;
  logic                             stage_busy;
  logic                             pop;
  logic                             not_empty;
  cir_pkg::res_beat_t               head;
  logic [cir_pkg::QCNT_W-1:0]       q_count;
  logic                             accept_read;

  // Hold off commands while the queue could overflow.
  assign busy   = (q_count + cir_pkg::QCNT_W'(stage_busy))
                  >= cir_pkg::QCNT_W'(cir_pkg::QUEUE_DEPTH);
  assign accept = start && !busy;
  assign accept_read = accept && (in_command == cir_pkg::CMD_READ);

  cir_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .sample_in  (in_sample_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_beat  (push_beat),
    .stage_busy (stage_busy)
  );

  cir_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_beat (push_beat),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .count     (q_count)
  );

  cir_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .not_empty      (not_empty),
    .head           (head),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_sample_out (out_sample_out),
    .out_last       (out_last),
    .out_empty_res  (out_empty_res)
  );

  // Every accepted read yields exactly one beat, and every beat stems from one.
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3))
      |-> (out_strobe == $past(accept_read, 3)))
    else $error("result beat does not match an accepted read");

  // An empty result carries zero data and is never the last of a frame.
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_empty_res) |-> ((out_sample_out == '0) && !out_last))
    else $error("empty result with data or last flag");

  // The result queue never overflows.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= cir_pkg::QCNT_W'(cir_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

endmodule
